// ----- design/bilateral_filter_5x5_rgb_assert.svh -----
// assertion macros for the bilateral filter
`ifndef BILATERAL_FILTER_5X5_RGB_ASSERT_SVH
`define BILATERAL_FILTER_5X5_RGB_ASSERT_SVH

// same-cycle implication
`define BFR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BFR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/bfr_pkg.sv -----
// shared types and constants of the bilateral filter
`timescale 1ns / 1ps

package bfr_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 2048;
	localparam int RADIUS_DEF     = 2;

	localparam logic [11:0] FRAME_WIDTH_RST  = 12'd1920;
	localparam logic [11:0] FRAME_HEIGHT_RST = 12'd1080;
	localparam logic [31:0] DOMAIN_SCALE_RST = 32'd932068;
	localparam logic [31:0] RANGE_SCALE_RST  = 32'd3225;

	// configuration register indexes
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DOMAIN_SCALE = 2'd2;
	localparam logic [1:0] REG_RANGE_SCALE  = 2'd3;

	// exponential approximation
	localparam int          EXP_SQUARINGS = 10;
	localparam int          EXP_ARG_W     = 51;
	localparam logic [16:0] WEIGHT_ONE    = 17'd65536;
	localparam logic [15:0] RECIP6        = 16'd43691;
	localparam logic [11:0] RECIP24       = 12'd2731;

	typedef struct packed {
		logic accept;
		logic begin_px;
		logic sel_center;
		logic rd_en;
		logic ld_ctr;
		logic ld_px;
		logic diff;
		logic mula;
		logic mulb;
		logic xsq;
		logic t3;
		logic t4;
		logic ycalc;
		logic sq_step;
		logic acc;
		logic div_init;
		logic div_step;
		logic ld_out;
	} cmd_t;

	typedef struct packed {
		logic fire;
		logic exp_short;
		logic sq_last;
		logic tap_last;
		logic div_last;
	} status_t;

endpackage

// ----- design/bfr_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module bfr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- design/bfr_datapath.sv -----
// counters, line store, weight and division datapath
`timescale 1ns / 1ps

module bfr_datapath #(
	parameter int MAX_WIDTH  = bfr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bfr_pkg::MAX_HEIGHT_DEF,
	parameter int RADIUS     = bfr_pkg::RADIUS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bfr_pkg::cmd_t    cmd,
	output bfr_pkg::status_t status,
	input  logic             action,
	input  logic [7:0]       in_red,
	input  logic [7:0]       in_green,
	input  logic [7:0]       in_blue,
	input  logic [7:0]       in_alpha,
	output logic [7:0]       out_red,
	output logic [7:0]       out_green,
	output logic [7:0]       out_blue,
	output logic [7:0]       out_alpha,
	output logic             frame_end,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_wdata
);

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int CNTW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int ICW   = CNTW + 1;
	localparam int AW    = $clog2(2 * RADIUS * MAX_WIDTH + 2 * RADIUS + 4);
	localparam int OW    = $clog2(RADIUS + 1) + 1;
	localparam int D2W   = 2 * OW + 1;
	localparam int TW    = CW + 2;
	localparam int TRW   = RW + 2;
	localparam int TAPS  = (2 * RADIUS + 1) * (2 * RADIUS + 1);
	localparam int SW    = $clog2(TAPS * 65536 + 1);
	localparam int CSW   = $clog2(TAPS * 65536 * 255 + 1);
	localparam int DCW   = $clog2(CSW);
	localparam int SQW   = $clog2(bfr_pkg::EXP_SQUARINGS);
	localparam int AXW   = bfr_pkg::EXP_ARG_W;
	localparam logic signed [OW-1:0] OFF_MIN = OW'(-RADIUS);
	localparam logic signed [OW-1:0] OFF_MAX = OW'(RADIUS);

	// configuration
	logic [11:0] fw_q, fh_q;
	logic [31:0] ds_q, rs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= bfr_pkg::FRAME_WIDTH_RST;
			fh_q <= bfr_pkg::FRAME_HEIGHT_RST;
			ds_q <= bfr_pkg::DOMAIN_SCALE_RST;
			rs_q <= bfr_pkg::RANGE_SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bfr_pkg::REG_FRAME_WIDTH:  fw_q <= cfg_wdata[11:0];
				bfr_pkg::REG_FRAME_HEIGHT: fh_q <= cfg_wdata[11:0];
				bfr_pkg::REG_DOMAIN_SCALE: ds_q <= cfg_wdata;
				bfr_pkg::REG_RANGE_SCALE:  rs_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [WW-1:0]   w_c;
	logic [HW-1:0]   h_c;
	logic [CNTW-1:0] total_c, lag_c;

	always_comb begin
		if (fw_q == 12'd0) w_c = WW'(1);
		else if (32'(fw_q) > 32'(MAX_WIDTH)) w_c = WW'(MAX_WIDTH);
		else w_c = WW'(fw_q);
		if (fh_q == 12'd0) h_c = HW'(1);
		else if (32'(fh_q) > 32'(MAX_HEIGHT)) h_c = HW'(MAX_HEIGHT);
		else h_c = HW'(fh_q);
	end

	assign total_c = CNTW'(w_c) * CNTW'(h_c);
	assign lag_c   = CNTW'(RADIUS) * CNTW'(w_c) + CNTW'(RADIUS);

	// stream counters
	logic [CNTW-1:0] got_q, out_lin_q;
	logic [ICW-1:0]  item_cnt_q;
	logic [CW-1:0]   out_col_q;
	logic [RW-1:0]   out_row_q;
	logic            in_full_c, counted_c, store_c, last_c, clr_c;

	assign in_full_c = got_q >= total_c;
	assign counted_c = in_full_c || !action;
	assign store_c   = cmd.accept && !in_full_c && !action;
	assign last_c    = out_lin_q == total_c - CNTW'(1);
	assign clr_c     = (cfg_we && (cfg_index == bfr_pkg::REG_FRAME_WIDTH
		|| cfg_index == bfr_pkg::REG_FRAME_HEIGHT)) || (cmd.ld_out && last_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			got_q      <= '0;
			item_cnt_q <= '0;
			out_lin_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
		end else if (clr_c) begin
			got_q      <= '0;
			item_cnt_q <= '0;
			out_lin_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
		end else begin
			if (cmd.accept && counted_c) begin
				item_cnt_q <= item_cnt_q + ICW'(1);
			end
			if (store_c) begin
				got_q <= got_q + CNTW'(1);
			end
			if (cmd.ld_out) begin
				out_lin_q <= out_lin_q + CNTW'(1);
				if (WW'(out_col_q) == w_c - WW'(1)) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + RW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	assign status.fire = counted_c && ((item_cnt_q + ICW'(1)) > ICW'(lag_c));

	// tap offsets
	logic signed [OW-1:0] tap_i_q, tap_j_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_i_q <= OFF_MIN;
			tap_j_q <= OFF_MIN;
		end else if (cmd.begin_px) begin
			tap_i_q <= OFF_MIN;
			tap_j_q <= OFF_MIN;
		end else if (cmd.acc) begin
			if (tap_i_q == OFF_MAX) begin
				tap_i_q <= OFF_MIN;
				tap_j_q <= tap_j_q + OW'(1);
			end else begin
				tap_i_q <= tap_i_q + OW'(1);
			end
		end
	end

	assign status.tap_last = (tap_i_q == OFF_MAX) && (tap_j_q == OFF_MAX);

	// tap address with border replication
	logic signed [TW-1:0]  tx_s, wm1_s;
	logic signed [TRW-1:0] ty_s, hm1_s;
	logic [CW-1:0]         tx_c;
	logic [RW-1:0]         ty_c;
	logic [CNTW-1:0]       lin_c;
	logic [AW-1:0]         rd_addr_c;
	logic [31:0]           rd_data;

	assign tx_s  = $signed({2'b00, out_col_q}) + {{(TW - OW){tap_i_q[OW-1]}}, tap_i_q};
	assign ty_s  = $signed({2'b00, out_row_q}) + {{(TRW - OW){tap_j_q[OW-1]}}, tap_j_q};
	assign wm1_s = $signed(TW'(w_c) - TW'(1));
	assign hm1_s = $signed(TRW'(h_c) - TRW'(1));

	always_comb begin
		if (tx_s < 0) tx_c = '0;
		else if (tx_s > wm1_s) tx_c = CW'(wm1_s);
		else tx_c = CW'(tx_s);
		if (ty_s < 0) ty_c = '0;
		else if (ty_s > hm1_s) ty_c = RW'(hm1_s);
		else ty_c = RW'(ty_s);
	end

	assign lin_c     = CNTW'(ty_c) * CNTW'(w_c) + CNTW'(tx_c);
	assign rd_addr_c = cmd.sel_center ? out_lin_q[AW-1:0] : lin_c[AW-1:0];

	bfr_ram #(
		.WIDTH(32),
		.DEPTH(1 << AW)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (store_c),
		.wr_addr(got_q[AW-1:0]),
		.wr_data({in_alpha, in_blue, in_green, in_red}),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr_c),
		.rd_data(rd_data)
	);

	// centre and tap pixels
	logic [31:0] ctr_q, px_q;

	always_ff @(posedge clk) begin
		if (cmd.ld_ctr) ctr_q <= rd_data;
		if (cmd.ld_px) px_q <= rd_data;
	end

	// distances and exponent argument
	logic signed [9:0]      dr_c, dg_c, db_c;
	logic signed [19:0]     dr2_c, dg2_c, db2_c;
	logic signed [2*OW-1:0] ii_c, jj_c;
	logic [17:0]            c2_q;
	logic [D2W-1:0]         d2_q;
	logic [49:0]            pa_q;
	logic [D2W+31:0]        pd_c;
	logic [AXW-1:0]         a_q;

	assign dr_c  = $signed({2'b00, px_q[7:0]}) - $signed({2'b00, ctr_q[7:0]});
	assign dg_c  = $signed({2'b00, px_q[15:8]}) - $signed({2'b00, ctr_q[15:8]});
	assign db_c  = $signed({2'b00, px_q[23:16]}) - $signed({2'b00, ctr_q[23:16]});
	assign dr2_c = dr_c * dr_c;
	assign dg2_c = dg_c * dg_c;
	assign db2_c = db_c * db_c;
	assign ii_c  = tap_i_q * tap_i_q;
	assign jj_c  = tap_j_q * tap_j_q;
	assign pd_c  = d2_q * ds_q;

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			c2_q <= 18'(dr2_c[16:0]) + 18'(dg2_c[16:0]) + 18'(db2_c[16:0]);
			d2_q <= D2W'($unsigned(ii_c)) + D2W'($unsigned(jj_c));
		end
		if (cmd.mula) pa_q <= c2_q * rs_q;
		if (cmd.mulb) a_q <= AXW'(pa_q) + AXW'(pd_c);
	end

	// exponential: series start then repeated squaring
	logic        big_c;
	logic [25:0] xa_c, x_q;
	logic [51:0] sqx_c;
	logic [45:0] p3_c;
	logic [39:0] p4_c;
	logic [29:0] p6_c;
	logic [19:0] p24_c;
	logic [19:0] t2_q;
	logic [13:0] t3_q;
	logic [7:0]  t4_q;
	logic [11:0] t3d6_q;
	logic [33:0] y_c;
	logic [31:0] y_q;
	logic [63:0] ysq_c;
	logic [SQW-1:0] sq_cnt_q;
	logic        short_q;
	logic [16:0] short_wt_q, wt_c;

	assign big_c = |a_q[AXW-1:28];
	assign xa_c  = a_q[27:2];
	assign sqx_c = xa_c * xa_c;
	assign p3_c  = t2_q * x_q;
	assign p4_c  = t3_q * x_q;
	assign p6_c  = t3_q * bfr_pkg::RECIP6;
	assign p24_c = t4_q * bfr_pkg::RECIP24;
	assign y_c   = (34'd1 << 32) + 34'(t2_q[19:1]) + 34'(p24_c[19:16])
		- 34'(x_q) - 34'(t3d6_q);
	assign ysq_c = y_q * y_q;

	assign status.exp_short = big_c || (xa_c == 26'd0);
	assign status.sq_last   = sq_cnt_q == SQW'(bfr_pkg::EXP_SQUARINGS - 1);

	always_ff @(posedge clk) begin
		if (cmd.xsq) begin
			short_q    <= big_c || (xa_c == 26'd0);
			short_wt_q <= big_c ? 17'd0 : bfr_pkg::WEIGHT_ONE;
			x_q        <= xa_c;
			t2_q       <= sqx_c[51:32];
		end
		if (cmd.t3) t3_q <= p3_c[45:32];
		if (cmd.t4) begin
			t4_q   <= p4_c[39:32];
			t3d6_q <= p6_c[29:18];
		end
		if (cmd.ycalc) y_q <= y_c[31:0];
		else if (cmd.sq_step) y_q <= ysq_c[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_cnt_q <= '0;
		end else if (cmd.ycalc) begin
			sq_cnt_q <= '0;
		end else if (cmd.sq_step) begin
			sq_cnt_q <= sq_cnt_q + SQW'(1);
		end
	end

	assign wt_c = short_q ? short_wt_q : {1'b0, y_q[31:16]};

	// weighted sums
	logic [SW-1:0]  wsum_q;
	logic [CSW-1:0] sum_q [3];

	always_ff @(posedge clk) begin
		if (cmd.begin_px) begin
			wsum_q <= '0;
			for (int c = 0; c < 3; c++) sum_q[c] <= '0;
		end else if (cmd.acc) begin
			wsum_q <= wsum_q + SW'(wt_c);
			for (int c = 0; c < 3; c++) begin
				sum_q[c] <= sum_q[c] + CSW'(wt_c * px_q[8*c +: 8]);
			end
		end
	end

	// restoring division, one quotient bit per cycle on each channel
	logic [CSW-1:0] num_q [3];
	logic [SW:0]    rem_q [3];
	logic [SW:0]    rsh_c [3];
	logic [DCW-1:0] div_cnt_q;
	logic [7:0]     quo_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rsh_c[c] = {rem_q[c][SW-1:0], num_q[c][CSW-1]};
			quo_c[c] = (num_q[c] > CSW'(255)) ? 8'd255 : num_q[c][7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			for (int c = 0; c < 3; c++) begin
				num_q[c] <= sum_q[c];
				rem_q[c] <= '0;
			end
		end else if (cmd.div_step) begin
			for (int c = 0; c < 3; c++) begin
				if (rsh_c[c] >= {1'b0, wsum_q}) begin
					rem_q[c] <= rsh_c[c] - {1'b0, wsum_q};
					num_q[c] <= {num_q[c][CSW-2:0], 1'b1};
				end else begin
					rem_q[c] <= rsh_c[c];
					num_q[c] <= {num_q[c][CSW-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_init) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + DCW'(1);
		end
	end

	assign status.div_last = div_cnt_q == DCW'(CSW - 1);

	// output register
	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			out_red   <= quo_c[0];
			out_green <= quo_c[1];
			out_blue  <= quo_c[2];
			out_alpha <= ctr_q[31:24];
			frame_end <= last_c;
		end
	end

endmodule

// ----- design/bfr_ctrl.sv -----
// sequencer of the bilateral filter
`timescale 1ns / 1ps
`include "bilateral_filter_5x5_rgb_assert.svh"

module bfr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output bfr_pkg::cmd_t    cmd,
	input  bfr_pkg::status_t status
);

	typedef enum logic [16:0] {
		S_IDLE  = 17'b00000000000000001,
		S_CRD   = 17'b00000000000000010,
		S_CLD   = 17'b00000000000000100,
		S_TRD   = 17'b00000000000001000,
		S_TLD   = 17'b00000000000010000,
		S_DIFF  = 17'b00000000000100000,
		S_MULA  = 17'b00000000001000000,
		S_MULB  = 17'b00000000010000000,
		S_XSQ   = 17'b00000000100000000,
		S_T3    = 17'b00000001000000000,
		S_T4    = 17'b00000010000000000,
		S_YCALC = 17'b00000100000000000,
		S_SQR   = 17'b00001000000000000,
		S_ACC   = 17'b00010000000000000,
		S_DINIT = 17'b00100000000000000,
		S_DIV   = 17'b01000000000000000,
		S_OUT   = 17'b10000000000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_free_c;

	assign in_stall   = state_q != S_IDLE;
	assign out_free_c = !out_valid || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && status.fire) state_d = S_CRD;
			end
			S_CRD: begin
				cmd.begin_px   = 1'b1;
				cmd.sel_center = 1'b1;
				cmd.rd_en      = 1'b1;
				state_d        = S_CLD;
			end
			S_CLD: begin
				cmd.ld_ctr = 1'b1;
				state_d    = S_TRD;
			end
			S_TRD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_TLD;
			end
			S_TLD: begin
				cmd.ld_px = 1'b1;
				state_d   = S_DIFF;
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_MULA;
			end
			S_MULA: begin
				cmd.mula = 1'b1;
				state_d  = S_MULB;
			end
			S_MULB: begin
				cmd.mulb = 1'b1;
				state_d  = S_XSQ;
			end
			S_XSQ: begin
				cmd.xsq = 1'b1;
				state_d = status.exp_short ? S_ACC : S_T3;
			end
			S_T3: begin
				cmd.t3  = 1'b1;
				state_d = S_T4;
			end
			S_T4: begin
				cmd.t4  = 1'b1;
				state_d = S_YCALC;
			end
			S_YCALC: begin
				cmd.ycalc = 1'b1;
				state_d   = S_SQR;
			end
			S_SQR: begin
				cmd.sq_step = 1'b1;
				if (status.sq_last) state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = status.tap_last ? S_DINIT : S_TRD;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) state_d = S_OUT;
			end
			S_OUT: begin
				// wait until the previous result has been taken
				if (out_free_c) begin
					cmd.ld_out = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_out) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	`BFR_ASSERT_NXT(a_out_wait, clk, arst_n, state_q == S_OUT && out_valid && out_stall, state_q == S_OUT, "result overwritten while stalled")
	`BFR_ASSERT_NXT(a_sq_done, clk, arst_n, state_q == S_SQR && status.sq_last, state_q == S_ACC, "squaring count overrun")
	`BFR_ASSERT_NXT(a_no_fire, clk, arst_n, state_q == S_IDLE && in_valid && !status.fire, state_q == S_IDLE, "work started for an item without a result")

endmodule

// ----- design/bilateral_filter_5x5_rgb.sv -----
// top level of the 5x5 bilateral filter on an rgba raster stream
//
//  channel  direction  handshake            payload
//  input    in         in_valid / in_stall  action, in_red, in_green, in_blue, in_alpha
//  output   out        out_valid/out_stall  out_red, out_green, out_blue, out_alpha, frame_end
//  config   in         cfg_we               cfg_index, cfg_wdata
//
// an item giving no result is taken while the sequencer stays idle; one giving a result
// runs the sequencer over every tap, then the bit-serial divider on the CSW-bit sums
// (CSW = 29 at radius 2). a tap whose argument is clipped or zero skips the series and
// squarings. the run time is set by the shared exponential unit (ten squarings on one
// multiplier) and the divider. reset clears all counters; no clearing pass is run.
// a stalled output holds the sequencer before the next result is loaded.
`timescale 1ns / 1ps

module bilateral_filter_5x5_rgb #(
	parameter int MAX_WIDTH  = bfr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bfr_pkg::MAX_HEIGHT_DEF,
	parameter int RADIUS     = bfr_pkg::RADIUS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	input  logic [7:0]  in_alpha,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha,
	output logic        frame_end,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	bfr_pkg::cmd_t    cmd;
	bfr_pkg::status_t status;

	bfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.status   (status)
	);

	bfr_datapath #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.RADIUS    (RADIUS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.action   (action),
		.in_red   (in_red),
		.in_green (in_green),
		.in_blue  (in_blue),
		.in_alpha (in_alpha),
		.out_red  (out_red),
		.out_green(out_green),
		.out_blue (out_blue),
		.out_alpha(out_alpha),
		.frame_end(frame_end),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

endmodule
